// File: rtl/assert_macros.svh
// Assertion macros for the RTL of the index stream parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");

// Checks that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

// File: rtl/idx2sp_pkg.sv
// Package with the types and constants of the index stream parser.
`timescale 1ns / 1ps
`default_nettype none

package idx2sp_pkg;

	// Parser phases.
	typedef enum logic [2:0] {
		PH_HEADER,
		PH_FIXED,
		PH_PATH,
		PH_PAD,
		PH_DONE,
		PH_ERROR
	} phase_t;

	// Result kinds.
	localparam logic [3:0] KIND_COUNT      = 4'd0;
	localparam logic [3:0] KIND_META_FIRST = 4'd1;
	localparam logic [3:0] KIND_ID         = 4'd11;
	localparam logic [3:0] KIND_FLAGS      = 4'd12;
	localparam logic [3:0] KIND_PATH       = 4'd13;
	localparam logic [3:0] KIND_ENTRY_END  = 4'd14;
	localparam logic [3:0] KIND_STATUS     = 4'd15;

	// Status codes.
	localparam logic [2:0] ST_NONE   = 3'd0;
	localparam logic [2:0] ST_OK     = 3'd1;
	localparam logic [2:0] ST_SHORT  = 3'd2;
	localparam logic [2:0] ST_BADSIG = 3'd3;
	localparam logic [2:0] ST_BADVER = 3'd4;
	localparam logic [2:0] ST_TRUNC  = 3'd5;

	// Header and entry layout.
	localparam logic [7:0] SIG_BYTES [4] = '{8'h44, 8'h49, 8'h52, 8'h43};
	localparam logic [7:0] VERSION_LOW     = 8'd2;
	localparam logic [5:0] SIG_END_POS     = 6'd4;
	localparam logic [5:0] VER_END_POS     = 6'd8;
	localparam logic [5:0] VER_LOW_POS     = 6'd7;
	localparam logic [5:0] HDR_LAST_POS    = 6'd11;
	localparam logic [5:0] META_END_POS    = 6'd40;
	localparam logic [5:0] ID_END_POS      = 6'd60;
	localparam logic [2:0] ALIGN_AFTER_FIX = 3'd6;

	// Depth of the result queue.
	localparam int QDEPTH = 4;

	// One result item.
	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] value;
		logic [2:0]  status;
		logic        last;
	} result_t;

	function automatic result_t mk_result(logic [3:0] kind, logic [31:0] value,
			logic [2:0] status);
		result_t r;
		r.kind   = kind;
		r.value  = value;
		r.status = status;
		r.last   = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/index_v2_stream_parser_top.sv
// Version-2 directory index parser: one file byte in, field results out.
// A byte accepted on the input is registered in the input stage; its results enter
// the output queue when that stage advances, and the queue head is offered.
// Throughput: one byte per cycle while the queue has room; the output side drains one
// result per cycle, so a byte that causes two results is drained as two items, and the
// input stalls while the four-entry result queue holds more than two results.
// Reset clears the parser state, the input stage and the result queue.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module index_v2_stream_parser_top
	import idx2sp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,   // end_of_stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [31:0] value, [34:32] status, zero fill
	output logic [3:0]       m_tuser,   // [3:0] kind
	output logic             m_tlast    // last_of_run
);

	localparam int CW = $clog2(QDEPTH + 1);

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;

	// Parser state.
	phase_t      phase_q;
	logic [5:0]  pos_q;
	logic [31:0] shift_q;
	logic [30:0] left_q;
	logic [2:0]  align_q;
	logic [2:0]  err_q;

	// Result queue.
	result_t       q_q [QDEPTH];
	result_t       q_d [QDEPTH];
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] base;

	// Next state and results of the registered byte.
	phase_t      n_phase;
	logic [5:0]  n_pos;
	logic [31:0] n_shift;
	logic [30:0] n_left;
	logic [2:0]  n_align;
	logic [2:0]  n_err;
	logic [31:0] shifted;
	logic [2:0]  a_inc;
	logic [2:0]  st;
	logic [7:0]  want;
	result_t     res [2];
	logic [1:0]  nres;

	logic pop;
	logic advance;

	assign pop      = m_tvalid && m_tready;
	assign advance  = valid_s1 && (cnt_q <= CW'(QDEPTH - 2));
	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eos_s1  <= s_tlast;
		end
	end

	// Parser step for the registered byte.
	always_comb begin
		n_phase = phase_q;
		n_pos   = pos_q;
		n_shift = shift_q;
		n_left  = left_q;
		n_align = align_q;
		n_err   = err_q;
		nres    = 2'd0;
		res[0]  = '0;
		res[1]  = '0;
		st      = ST_NONE;
		want    = 8'd0;
		shifted = {shift_q[23:0], byte_s1};
		a_inc   = align_q + 3'd1;

		unique case (phase_q)
			PH_HEADER: begin
				n_shift = shifted;
				if (pos_q < SIG_END_POS) begin
					if (byte_s1 != SIG_BYTES[pos_q[1:0]] && err_q == ST_NONE) begin
						n_err = ST_BADSIG;
					end
				end else if (pos_q < VER_END_POS) begin
					want = (pos_q == VER_LOW_POS) ? VERSION_LOW : 8'd0;
					if (byte_s1 != want && err_q == ST_NONE) begin
						n_err = ST_BADVER;
					end
				end
				if (pos_q >= HDR_LAST_POS) begin
					n_pos = 6'd0;
					if (n_err != ST_NONE) begin
						n_phase = PH_ERROR;
					end else begin
						res[0]  = mk_result(KIND_COUNT, shifted, ST_NONE);
						nres    = 2'd1;
						n_left  = shifted[31] ? 31'd0 : shifted[30:0];
						n_phase = (n_left != 31'd0) ? PH_FIXED : PH_DONE;
					end
				end else begin
					n_pos = pos_q + 6'd1;
				end
			end
			PH_FIXED: begin
				n_shift = shifted;
				if (pos_q < META_END_POS) begin
					if (pos_q[1:0] == 2'd3) begin
						res[0] = mk_result(KIND_META_FIRST + pos_q[5:2], shifted,
							ST_NONE);
						nres   = 2'd1;
					end
					n_pos = pos_q + 6'd1;
				end else if (pos_q < ID_END_POS) begin
					res[0] = mk_result(KIND_ID, {24'd0, byte_s1}, ST_NONE);
					nres   = 2'd1;
					n_pos  = pos_q + 6'd1;
				end else if (pos_q == ID_END_POS) begin
					n_pos = pos_q + 6'd1;
				end else begin
					res[0]  = mk_result(KIND_FLAGS, {16'd0, shifted[15:0]}, ST_NONE);
					nres    = 2'd1;
					n_phase = PH_PATH;
					n_align = ALIGN_AFTER_FIX;
					n_pos   = 6'd0;
				end
			end
			PH_PATH, PH_PAD: begin
				n_align = a_inc;
				if (phase_q == PH_PATH && byte_s1 != 8'd0) begin
					res[0] = mk_result(KIND_PATH, {24'd0, byte_s1}, ST_NONE);
					nres   = 2'd1;
				end else if (a_inc == 3'd0) begin
					// Entry is padded to a multiple of eight bytes: close it.
					res[0]  = mk_result(KIND_ENTRY_END, 32'd0, ST_NONE);
					nres    = 2'd1;
					n_left  = left_q - 31'd1;
					n_phase = (n_left != 31'd0) ? PH_FIXED : PH_DONE;
					n_pos   = 6'd0;
				end else begin
					n_phase = PH_PAD;
				end
			end
			default: begin
			end
		endcase

		// End of stream: report status and return to the reset state.
		if (eos_s1) begin
			if (n_phase == PH_ERROR) begin
				st = n_err;
			end else if (n_phase == PH_HEADER) begin
				st = ST_SHORT;
			end else if (n_phase == PH_DONE) begin
				st = ST_OK;
			end else if (n_phase == PH_PAD && n_left == 31'd1) begin
				res[nres[0]] = mk_result(KIND_ENTRY_END, 32'd0, ST_NONE);
				nres         = nres + 2'd1;
				st           = ST_OK;
			end else begin
				st = ST_TRUNC;
			end
			res[nres[0]] = mk_result(KIND_STATUS, 32'd0, st);
			nres         = nres + 2'd1;
			n_phase      = PH_HEADER;
			n_pos        = 6'd0;
			n_shift      = 32'd0;
			n_left       = 31'd0;
			n_align      = 3'd0;
			n_err        = ST_NONE;
		end

		// Mark the final result of this byte.
		if (nres == 2'd1) begin
			res[0].last = 1'b1;
		end else if (nres == 2'd2) begin
			res[1].last = 1'b1;
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= 6'd0;
			shift_q <= 32'd0;
			left_q  <= 31'd0;
			align_q <= 3'd0;
			err_q   <= ST_NONE;
		end else if (advance) begin
			phase_q <= n_phase;
			pos_q   <= n_pos;
			shift_q <= n_shift;
			left_q  <= n_left;
			align_q <= n_align;
			err_q   <= n_err;
		end
	end

	// Result queue: shifts down on a pop, takes up to two results behind the rest.
	assign base = cnt_q - CW'(pop);

	always_comb begin
		for (int i = 0; i < QDEPTH; i++) begin
			q_d[i] = (pop && i < QDEPTH - 1) ? q_q[i + 1] : q_q[i];
			if (advance && nres != 2'd0 && base == CW'(i)) begin
				q_d[i] = res[0];
			end
			if (advance && nres == 2'd2 && base + CW'(1) == CW'(i)) begin
				q_d[i] = res[1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QDEPTH; i++) begin
			q_q[i] <= q_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q - CW'(pop) + (advance ? CW'(nres) : CW'(0));
		end
	end

	// Output port.
	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = {5'd0, q_q[0].status, q_q[0].value};
	assign m_tuser  = q_q[0].kind;
	assign m_tlast  = q_q[0].last;

	// Checks.
	`ASSERT_NEVER(a_queue_overflow, cnt_q > CW'(QDEPTH))
	`ASSERT_CLK(a_status_is_last, (m_tvalid && m_tuser == KIND_STATUS) |-> m_tlast)
	`ASSERT_CLK(a_status_only_with_kind,
		(m_tvalid && m_tuser != KIND_STATUS) |-> (m_tdata[34:32] == ST_NONE))
	`ASSERT_CLK(a_eos_restarts, (advance && eos_s1) |=> (phase_q == PH_HEADER && err_q == ST_NONE))
	`ASSERT_CLK(a_stall_holds, (valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)))

endmodule

`default_nettype wire
